// ===== src/nrd_pkg.sv =====
// Shared types and constants for the NFC response deframer.
package nrd_pkg;

    localparam logic [7:0] PREAMBLE_ZERO  = 8'h00;
    localparam logic [7:0] PREAMBLE_START = 8'hFF;
    localparam logic [7:0] FRAME_ID_RESP  = 8'hD5;
    localparam logic [7:0] TARGET_ERR_MASK = 8'h3F;
    localparam logic [7:0] MIN_FRAME_LEN  = 8'd3;

    localparam logic [7:0] RST_MAX_PAYLOAD_LEN = 8'hFF;
    localparam logic [7:0] RST_RESPONSE_CODE   = 8'h41;

    // configuration register indexes
    localparam logic CFG_MAX_PAYLOAD_LEN = 1'b0;
    localparam logic CFG_RESPONSE_CODE   = 1'b1;

    // frame status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_PREAMBLE = 3'd1;
    localparam logic [2:0] ST_LCS      = 3'd2;
    localparam logic [2:0] ST_IDENT    = 3'd3;
    localparam logic [2:0] ST_TARGET   = 3'd4;
    localparam logic [2:0] ST_SHORT    = 3'd5;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic       frame_end;
        logic [2:0] frame_status;
        logic [5:0] target_error_bits;
    } t_result;

endpackage

// ===== src/nfc_response_deframer.sv =====
// Top level of the NFC response deframer: config registers, parser, output buffer.
//
// Usage:
//   Input channel (i_valid/o_ready) carries one received frame byte per word,
//   with i_frame_start high on the first byte of each response frame.
//   Output channel (o_valid/i_ready) carries one result word per payload byte,
//   or a single closing word for an empty payload or a failed header check.
//   Header bytes that pass their checks produce no output word.
//   Throughput: one byte per cycle while o_ready is high. Each result word is
//   registered in the output register, or in the skid stage if that one is
//   full and not taken. The parser state machine decides every byte combinationally.
//   Stall: when i_ready is low the output register holds its word and a
//   one-word skid stage absorbs one more result; o_ready drops only while
//   that skid stage is occupied.
//   Config: i_cfg_we writes i_cfg_data to register i_cfg_index
//   (0 max payload length, 1 expected response code) at the clock edge.
//   Reset (synchronous, active low): config returns to 255 and 0x41, the
//   parser idles until a frame start, both buffer stages empty.
module nfc_response_deframer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    input  logic       i_frame_start,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_payload_byte,
    output logic       o_payload_valid,
    output logic       o_frame_end,
    output logic [2:0] o_frame_status,
    output logic [5:0] o_target_error_bits,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    logic [7:0]       r_max_payload_len;
    logic [7:0]       r_response_code;
    logic             accept;
    logic             res_valid;
    nrd_pkg::t_result result;
    nrd_pkg::t_result out_result;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload_len <= nrd_pkg::RST_MAX_PAYLOAD_LEN;
            r_response_code   <= nrd_pkg::RST_RESPONSE_CODE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                nrd_pkg::CFG_MAX_PAYLOAD_LEN: r_max_payload_len <= i_cfg_data;
                nrd_pkg::CFG_RESPONSE_CODE:   r_response_code   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign accept = i_valid && o_ready;

    nrd_parser u_parser (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (accept),
        .i_rx_byte         (i_rx_byte),
        .i_frame_start     (i_frame_start),
        .i_max_payload_len (r_max_payload_len),
        .i_response_code   (r_response_code),
        .o_res_valid       (res_valid),
        .o_result          (result)
    );

    nrd_outbuf u_outbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (res_valid),
        .i_result   (result),
        .o_can_push (o_ready),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_result   (out_result)
    );

    assign o_payload_byte      = out_result.payload_byte;
    assign o_payload_valid     = out_result.payload_valid;
    assign o_frame_end         = out_result.frame_end;
    assign o_frame_status      = out_result.frame_status;
    assign o_target_error_bits = out_result.target_error_bits;

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_frame_status == nrd_pkg::ST_OK || o_frame_end))
        else $error("error status on a word that does not end the frame");

endmodule

// ===== src/nrd_parser.sv =====
// Byte-position state machine: checks header bytes and forwards payload.
module nrd_parser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_rx_byte,
    input  logic            i_frame_start,
    input  logic [7:0]      i_max_payload_len,
    input  logic [7:0]      i_response_code,
    output logic            o_res_valid,
    output nrd_pkg::t_result o_result
);

    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_PRE0    = 10'b00_0000_0010,
        S_PRE1    = 10'b00_0000_0100,
        S_PRE2    = 10'b00_0000_1000,
        S_LEN     = 10'b00_0001_0000,
        S_LCS     = 10'b00_0010_0000,
        S_IDENT   = 10'b00_0100_0000,
        S_CODE    = 10'b00_1000_0000,
        S_STATUS  = 10'b01_0000_0000,
        S_PAYLOAD = 10'b10_0000_0000
    } t_state;

    t_state     r_state, n_state, cur_state;
    logic [7:0] r_frame_len, n_frame_len;
    logic [7:0] r_left, n_left;
    logic [7:0] lcs_sum, avail_len, left_dec;
    logic [5:0] terr;

    assign cur_state = i_frame_start ? S_PRE0 : r_state;
    assign lcs_sum   = r_frame_len + i_rx_byte;
    assign avail_len = r_frame_len - nrd_pkg::MIN_FRAME_LEN;
    assign left_dec  = r_left - 8'd1;
    assign terr      = i_rx_byte[5:0] & nrd_pkg::TARGET_ERR_MASK[5:0];

    always_comb begin
        n_state     = r_state;
        n_frame_len = r_frame_len;
        n_left      = r_left;
        o_res_valid = 1'b0;
        o_result    = '{payload_byte: 8'd0, payload_valid: 1'b0, frame_end: 1'b1,
                        frame_status: nrd_pkg::ST_OK, target_error_bits: 6'd0};
        if (i_accept) begin
            unique case (cur_state)
                S_IDLE: begin
                end
                S_PRE0, S_PRE1: begin
                    if (i_rx_byte != nrd_pkg::PREAMBLE_ZERO) begin
                        o_res_valid           = 1'b1;
                        o_result.frame_status = nrd_pkg::ST_PREAMBLE;
                        n_state               = S_IDLE;
                    end else begin
                        n_state = (cur_state == S_PRE0) ? S_PRE1 : S_PRE2;
                    end
                end
                S_PRE2: begin
                    if (i_rx_byte != nrd_pkg::PREAMBLE_START) begin
                        o_res_valid           = 1'b1;
                        o_result.frame_status = nrd_pkg::ST_PREAMBLE;
                        n_state               = S_IDLE;
                    end else begin
                        n_state = S_LEN;
                    end
                end
                S_LEN: begin
                    n_frame_len = i_rx_byte;
                    n_state     = S_LCS;
                end
                S_LCS: begin
                    if (lcs_sum != 8'd0) begin
                        o_res_valid           = 1'b1;
                        o_result.frame_status = nrd_pkg::ST_LCS;
                        n_state               = S_IDLE;
                    end else if (r_frame_len < nrd_pkg::MIN_FRAME_LEN) begin
                        o_res_valid           = 1'b1;
                        o_result.frame_status = nrd_pkg::ST_SHORT;
                        n_state               = S_IDLE;
                    end else begin
                        n_state = S_IDENT;
                    end
                end
                S_IDENT: begin
                    if (i_rx_byte != nrd_pkg::FRAME_ID_RESP) begin
                        o_res_valid           = 1'b1;
                        o_result.frame_status = nrd_pkg::ST_IDENT;
                        n_state               = S_IDLE;
                    end else begin
                        n_state = S_CODE;
                    end
                end
                S_CODE: begin
                    if (i_rx_byte != i_response_code) begin
                        o_res_valid           = 1'b1;
                        o_result.frame_status = nrd_pkg::ST_IDENT;
                        n_state               = S_IDLE;
                    end else begin
                        n_state = S_STATUS;
                    end
                end
                S_STATUS: begin
                    n_left = (avail_len > i_max_payload_len) ? i_max_payload_len
                                                              : avail_len;
                    if (terr != 6'd0) begin
                        o_res_valid                = 1'b1;
                        o_result.frame_status      = nrd_pkg::ST_TARGET;
                        o_result.target_error_bits = terr;
                        n_left                     = r_left;
                        n_state                    = S_IDLE;
                    end else if (n_left == 8'd0) begin
                        // empty payload: one closing word
                        o_res_valid = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        n_state = S_PAYLOAD;
                    end
                end
                S_PAYLOAD: begin
                    n_left                 = left_dec;
                    o_res_valid            = 1'b1;
                    o_result.payload_byte  = i_rx_byte;
                    o_result.payload_valid = 1'b1;
                    o_result.frame_end     = (left_dec == 8'd0);
                    if (left_dec == 8'd0) begin
                        n_state = S_IDLE;
                    end
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_frame_len <= 8'd0;
            r_left      <= 8'd0;
        end else begin
            r_state     <= n_state;
            r_frame_len <= n_frame_len;
            r_left      <= n_left;
        end
    end

    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_accept |=> $stable(r_state))
        else $error("parser state moved without an accepted word");

    a_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_result.frame_end) |=> (r_state == S_IDLE))
        else $error("frame ended but parser not idle");

    a_mid_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_result.frame_end) |=>
            (r_state == S_PAYLOAD && r_left != 8'd0))
        else $error("payload continues without bytes left");

endmodule

// ===== src/nrd_outbuf.sv =====
// Result register with a skid stage so input ready is registered and never waits combinationally on the sink.
module nrd_outbuf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  nrd_pkg::t_result i_result,
    output logic             o_can_push,
    output logic             o_valid,
    input  logic             i_ready,
    output nrd_pkg::t_result o_result
);

    logic             r_out_valid, r_skid_valid;
    nrd_pkg::t_result r_out, r_skid;
    logic             take, load_out, load_skid;

    assign take       = r_out_valid && i_ready;
    assign o_can_push = !r_skid_valid;
    assign o_valid    = r_out_valid;
    assign o_result   = r_out;
    assign load_out   = !r_skid_valid && i_push && (!r_out_valid || take);
    assign load_skid  = !r_skid_valid && i_push && r_out_valid && !take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            r_out_valid  <= 1'b1;
            r_skid_valid <= r_out_valid && !take;
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid && take) begin
            r_out <= r_skid;
        end else if (load_out) begin
            r_out <= i_result;
        end
        if (load_skid) begin
            r_skid <= i_result;
        end
    end

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word held with empty output register");

    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && o_can_push && !r_out_valid) |=> (r_out_valid && !r_skid_valid))
        else $error("word pushed into empty buffer did not land in output");

endmodule
